FILE: sv/bdlp_pkg.sv
// ----------------------------------------------------------------------------
// bdlp_pkg
// Types, constants and helpers shared by the button debouncer and its
// per-button state machine.
// ----------------------------------------------------------------------------
`default_nettype none

package bdlp_pkg;

   localparam int LINES           = 3;
   localparam int DEF_NUM_BUTTONS = 3;
   localparam int TIME_W          = 16;
   localparam int ELAPSED_W       = 8;
   localparam int CODE_W          = 3;
   localparam int CSR_INDEX_W     = 2;
   localparam int CSR_DATA_W      = 16;

   localparam logic [LINES-1:0]  RST_ACTIVE_LEVEL_MASK = 3'd0;
   localparam logic [TIME_W-1:0] RST_LONG_PRESS_MS     = 16'd500;
   localparam logic [TIME_W-1:0] RST_DEBOUNCE_MS       = 16'd20;

   localparam logic [CSR_INDEX_W-1:0] CSR_ACTIVE_LEVEL_MASK = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LONG_PRESS_MS     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEBOUNCE_MS       = 2'd2;

   localparam logic [CODE_W-1:0] CODE_UP           = 3'd0;
   localparam logic [CODE_W-1:0] CODE_DEBOUNCE     = 3'd1;
   localparam logic [CODE_W-1:0] CODE_CONFIRMED    = 3'd2;
   localparam logic [CODE_W-1:0] CODE_PRESSED      = 3'd3;
   localparam logic [CODE_W-1:0] CODE_LONG         = 3'd4;
   localparam logic [CODE_W-1:0] CODE_RELEASE      = 3'd5;
   localparam logic [CODE_W-1:0] CODE_LONG_RELEASE = 3'd6;

   typedef enum logic [6:0] {
      ST_UP           = 7'b0000001,
      ST_DEBOUNCE     = 7'b0000010,
      ST_CONFIRMED    = 7'b0000100,
      ST_PRESSED      = 7'b0001000,
      ST_LONG         = 7'b0010000,
      ST_RELEASE      = 7'b0100000,
      ST_LONG_RELEASE = 7'b1000000
   } state_type;

   typedef struct packed {
      logic [TIME_W-1:0] long_press_ms;
      logic [TIME_W-1:0] debounce_ms;
   } cfg_type;

   typedef struct packed {
      logic [LINES-1:0]     button_levels;
      logic [ELAPSED_W-1:0] elapsed_ms;
   } req_type;

   typedef struct packed {
      logic [CODE_W-1:0] state_first;
      logic [CODE_W-1:0] state_second;
      logic [CODE_W-1:0] state_third;
      logic [LINES-1:0]  level_echo;
   } rsp_type;

   function automatic logic [CODE_W-1:0] state_code(input state_type s);
      logic [CODE_W-1:0] c;
      case (s)
         ST_DEBOUNCE:     c = CODE_DEBOUNCE;
         ST_CONFIRMED:    c = CODE_CONFIRMED;
         ST_PRESSED:      c = CODE_PRESSED;
         ST_LONG:         c = CODE_LONG;
         ST_RELEASE:      c = CODE_RELEASE;
         ST_LONG_RELEASE: c = CODE_LONG_RELEASE;
         default:         c = CODE_UP;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

FILE: sv/button_debounce_long_press.sv
// Path: a request beat is taken into the input register and moves on to the result
//   register when that register is empty or its beat is being taken.
// Throughput: one request beat per cycle while results are not stalled; the
//   per-button add, compare and state update fit between input and result registers.
// Reset (synchronous): all buttons go up, held times clear, registers take
//   their defaults (mask 0, long press 500, debounce 20).
// ----------------------------------------------------------------------------
// button_debounce_long_press
// Scan-tick debouncer for several buttons with long-press detection.
// ----------------------------------------------------------------------------
`default_nettype none

module button_debounce_long_press #(
   parameter int NUM_BUTTONS = bdlp_pkg::DEF_NUM_BUTTONS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,

   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire bdlp_pkg::req_type                   req_data,

   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output bdlp_pkg::rsp_type                        rsp_data,

   input  wire logic                                csr_write_en,
   input  wire logic [bdlp_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [bdlp_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   logic [bdlp_pkg::LINES-1:0]   mask_ff;
   bdlp_pkg::cfg_type            cfg_ff;

   logic                         in_valid_ff;
   bdlp_pkg::req_type            in_ff;
   logic                         out_valid_ff;
   bdlp_pkg::rsp_type            out_ff;
   bdlp_pkg::rsp_type            out_in;

   logic                         req_take;
   logic                         step_en;

   logic [bdlp_pkg::CODE_W-1:0]  next_code [NUM_BUTTONS];
   logic [bdlp_pkg::CODE_W-1:0]  line_code [bdlp_pkg::LINES];

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff              <= bdlp_pkg::RST_ACTIVE_LEVEL_MASK;
         cfg_ff.long_press_ms <= bdlp_pkg::RST_LONG_PRESS_MS;
         cfg_ff.debounce_ms   <= bdlp_pkg::RST_DEBOUNCE_MS;
      end else if (csr_write_en) begin
         case (csr_index)
            bdlp_pkg::CSR_ACTIVE_LEVEL_MASK: mask_ff <= csr_wdata[bdlp_pkg::LINES-1:0];
            bdlp_pkg::CSR_LONG_PRESS_MS:     cfg_ff.long_press_ms <= csr_wdata;
            bdlp_pkg::CSR_DEBOUNCE_MS:       cfg_ff.debounce_ms <= csr_wdata;
            default: ;
         endcase
      end
   end

   // advance when the input stage holds a beat and the result stage is empty or its beat is being taken
   assign step_en   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !step_en;
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (step_en) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_ff <= req_data;
      end
   end

   for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_button
      logic press;
      if (g < bdlp_pkg::LINES) begin : g_line
         assign press = (in_ff.button_levels[g] == mask_ff[g]);
      end else begin : g_no_line
         assign press = 1'b0;
      end

      bdlp_button u_button (
         .clock      (clock),
         .reset      (reset),
         .step_en    (step_en),
         .press      (press),
         .elapsed_ms (in_ff.elapsed_ms),
         .cfg        (cfg_ff),
         .next_code  (next_code[g])
      );
   end

   for (genvar g = 0; g < bdlp_pkg::LINES; g++) begin : g_out
      if (g < NUM_BUTTONS) begin : g_live
         assign line_code[g] = next_code[g];
      end else begin : g_absent
         assign line_code[g] = bdlp_pkg::CODE_UP;
      end
   end

   always_comb begin
      out_in.state_first  = line_code[0];
      out_in.state_second = line_code[1];
      out_in.state_third  = line_code[2];
      out_in.level_echo   = in_ff.button_levels;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (step_en) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

`ifndef SYNTHESIS
   a_take_fills_input: assert property (@(posedge clock) disable iff (reset)
      req_take |=> in_valid_ff)
      else $error("accepted request beat not held in input stage");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && out_valid_ff && rsp_stall))
      else $error("request stalled without a blocked result beat");

   a_step_gives_result: assert property (@(posedge clock) disable iff (reset)
      step_en |=> rsp_valid)
      else $error("state step produced no result beat");

   a_drain_empties_output: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !in_valid_ff) |=> !rsp_valid)
      else $error("result beat repeated after it was taken");

   a_echo_matches_input: assert property (@(posedge clock) disable iff (reset)
      step_en |=> (rsp_data.level_echo == $past(in_ff.button_levels)))
      else $error("level echo does not match the stepped beat");
`endif

endmodule

`default_nettype wire

FILE: sv/bdlp_button.sv
// ----------------------------------------------------------------------------
// bdlp_button
// Seven-state debounce and long-press machine for one button, with a
// saturating held-time counter.
// ----------------------------------------------------------------------------
`default_nettype none

module bdlp_button (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              step_en,
   input  wire logic                              press,
   input  wire logic [bdlp_pkg::ELAPSED_W-1:0]    elapsed_ms,
   input  wire bdlp_pkg::cfg_type                 cfg,
   output logic      [bdlp_pkg::CODE_W-1:0]       next_code
);

   bdlp_pkg::state_type              state_ff;
   bdlp_pkg::state_type              state_in;
   logic [bdlp_pkg::TIME_W-1:0]      held_ff;
   logic [bdlp_pkg::TIME_W-1:0]      held_in;
   logic [bdlp_pkg::TIME_W:0]        held_sum;
   logic [bdlp_pkg::TIME_W-1:0]      held_sat;

   always_comb begin
      held_sum = {1'b0, held_ff} +
                 {{(bdlp_pkg::TIME_W + 1 - bdlp_pkg::ELAPSED_W){1'b0}}, elapsed_ms};
      held_sat = held_sum[bdlp_pkg::TIME_W] ? '1 : held_sum[bdlp_pkg::TIME_W-1:0];
   end

   always_comb begin
      state_in = state_ff;
      held_in  = held_ff;
      case (state_ff)
         bdlp_pkg::ST_DEBOUNCE: begin
            if (press) begin
               held_in = held_sat;
               if (held_sat > cfg.debounce_ms) begin
                  state_in = bdlp_pkg::ST_CONFIRMED;
                  held_in  = '0;
               end
            end else begin
               state_in = bdlp_pkg::ST_UP;
               held_in  = '0;
            end
         end
         bdlp_pkg::ST_CONFIRMED: begin
            if (press) begin
               state_in = bdlp_pkg::ST_PRESSED;
               held_in  = '0;
            end else begin
               state_in = bdlp_pkg::ST_UP;
            end
         end
         bdlp_pkg::ST_PRESSED: begin
            if (press) begin
               held_in = held_sat;
               if (held_sat > cfg.long_press_ms) begin
                  state_in = bdlp_pkg::ST_LONG;
                  held_in  = '0;
               end
            end else begin
               state_in = bdlp_pkg::ST_RELEASE;
               held_in  = '0;
            end
         end
         bdlp_pkg::ST_LONG: begin
            state_in = press ? bdlp_pkg::ST_LONG : bdlp_pkg::ST_LONG_RELEASE;
         end
         bdlp_pkg::ST_RELEASE, bdlp_pkg::ST_LONG_RELEASE: begin
            state_in = bdlp_pkg::ST_UP;
         end
         default: begin
            if (press) begin
               state_in = bdlp_pkg::ST_DEBOUNCE;
               held_in  = '0;
            end else begin
               state_in = bdlp_pkg::ST_UP;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bdlp_pkg::ST_UP;
         held_ff  <= '0;
      end else if (step_en) begin
         state_ff <= state_in;
         held_ff  <= held_in;
      end
   end

   assign next_code = bdlp_pkg::state_code(state_in);

endmodule

`default_nettype wire
